FILE: rtl/cvkt_pkg.sv
`timescale 1ns / 1ps

package cvkt_pkg;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROC_POS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROC_VEL = 2'd3;

    localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] ONE = DW'(1) << FB;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MEAS,
        OP_P,
        OP_T,
        OP_A1,
        OP_A2,
        OP_A3,
        OP_S,
        OP_DIV1,
        OP_DIV2,
        OP_UP,
        OP_UV,
        OP_UA,
        OP_UB,
        OP_UC
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] axis;
        logic       div_start;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic s_pos;
    } sts_t;

    function automatic logic signed [DW-1:0] sat_add(
        input logic signed [DW-1:0] a, input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) return s[DW] ? VMIN : VMAX;
        return s[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] sat_sub(
        input logic signed [DW-1:0] a, input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} - {b[DW-1], b};
        if (s[DW] != s[DW-1]) return s[DW] ? VMIN : VMAX;
        return s[DW-1:0];
    endfunction

    // Rounded, saturated fixed-point product.
    function automatic logic signed [DW-1:0] fx_mul(
        input logic signed [DW-1:0] a, input logic signed [DW-1:0] b);
        logic [DW-1:0] ma;
        logic [DW-1:0] mb;
        logic [2*DW:0] p;
        logic [2*DW:0] q;
        logic neg;
        ma = a[DW-1] ? DW'(-a) : DW'(a);
        mb = b[DW-1] ? DW'(-b) : DW'(b);
        neg = a[DW-1] ^ b[DW-1];
        p = (2*DW+1)'(ma) * (2*DW+1)'(mb) + ((2*DW+1)'(1) << (FB-1));
        q = p >> FB;
        if (neg) begin
            if (q > (2*DW+1)'({1'b1, {(DW-1){1'b0}}})) return VMIN;
            return DW'(-q[DW-1:0]);
        end
        if (q > (2*DW+1)'(VMAX)) return VMAX;
        return q[DW-1:0];
    endfunction

endpackage

FILE: rtl/constant_velocity_kalman_tracker_core.sv
`timescale 1ns / 1ps

// Constant-velocity tracker for a 3D point in signed Q16.16.
// Input channel: in_valid / in_stall with meas_x, meas_y, meas_z; a transaction
// takes place at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with pos_* and vel_*.
// The first transaction after reset only loads the position and gives no
// result. Each later one runs predict and update for the three axes in turn
// on one shared multiply step and one bit-serial divider; each axis runs two
// divisions when its innovation variance is positive and none when it is not.
// No new measurement is taken until the result of the last one is out. The
// result is held on the output ports while out_stall is high; a new
// measurement is taken in the same cycle as the result transaction.
// Configuration: cfg_we, cfg_index, cfg_data write time_step, meas_noise,
// proc_noise_pos and proc_noise_vel (indexes 0 to 3); the user must write
// them only while the block is idle, which the block does not enforce.
// Reset (rst_n low, asynchronous) restores the register defaults, unit
// covariance and zero state, and drops any pending result.
module constant_velocity_kalman_tracker_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] meas_x,
    input  logic signed [31:0] meas_y,
    input  logic signed [31:0] meas_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [31:0] vel_x,
    output logic signed [31:0] vel_y,
    output logic signed [31:0] vel_z
);
    cvkt_pkg::cmd_t cmd;
    cvkt_pkg::sts_t sts;

    cvkt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    cvkt_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_index),
        .cfg_data (cfg_data),
        .meas_x   (meas_x),
        .meas_y   (meas_y),
        .meas_z   (meas_z),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .pos_z    (pos_z),
        .vel_x    (vel_x),
        .vel_y    (vel_y),
        .vel_z    (vel_z)
    );
endmodule

FILE: rtl/cvkt_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle: round(n * 2^FB / d).
module cvkt_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [cvkt_pkg::DW-1:0] num,
    input  logic signed [cvkt_pkg::DW-1:0] den,
    output logic                         busy,
    output logic signed [cvkt_pkg::DW-1:0] quot
);
    localparam int NW = cvkt_pkg::DW + cvkt_pkg::FB + 1;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]            num_reg;
    logic [NW-1:0]            q_reg;
    logic [cvkt_pkg::DW:0]    rem_reg;
    logic [cvkt_pkg::DW-1:0]  den_reg;
    logic                     neg_reg;
    logic [CW-1:0]            cnt_reg;
    logic [cvkt_pkg::DW:0]    trial;
    logic [cvkt_pkg::DW-1:0]  mn;

    assign busy = (cnt_reg != '0);
    assign mn = num[cvkt_pkg::DW-1] ? cvkt_pkg::DW'(-num) : cvkt_pkg::DW'(num);
    assign trial = {rem_reg[cvkt_pkg::DW-1:0], num_reg[NW-1]};

    // Iteration register set.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(NW);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= (NW'(mn) << cvkt_pkg::FB) + NW'(den[cvkt_pkg::DW-1:1]);
            den_reg <= den;
            neg_reg <= num[cvkt_pkg::DW-1];
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy)
        begin
            num_reg <= num_reg << 1;
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= trial - {1'b0, den_reg};
                q_reg   <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    // Saturating sign restore.
    always_comb
    begin
        if (neg_reg)
        begin
            if (q_reg > NW'({1'b1, {(cvkt_pkg::DW-1){1'b0}}})) quot = cvkt_pkg::VMIN;
            else quot = cvkt_pkg::DW'(-q_reg[cvkt_pkg::DW-1:0]);
        end
        else
        begin
            if (q_reg > NW'(cvkt_pkg::VMAX)) quot = cvkt_pkg::VMAX;
            else quot = q_reg[cvkt_pkg::DW-1:0];
        end
    end
endmodule

FILE: rtl/cvkt_datapath.sv
`timescale 1ns / 1ps

// Per-axis filter state and a shared multiply/add step; one operation per cycle.
module cvkt_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cvkt_pkg::cmd_t                 cmd,
    output cvkt_pkg::sts_t                 sts,
    input  logic                           cfg_we,
    input  logic [cvkt_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [cvkt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic signed [31:0]             meas_x,
    input  logic signed [31:0]             meas_y,
    input  logic signed [31:0]             meas_z,
    output logic signed [31:0]             pos_x,
    output logic signed [31:0]             pos_y,
    output logic signed [31:0]             pos_z,
    output logic signed [31:0]             vel_x,
    output logic signed [31:0]             vel_y,
    output logic signed [31:0]             vel_z
);
    localparam int DW = cvkt_pkg::DW;
    typedef logic signed [DW-1:0] val_t;

    logic [15:0] dt_reg;
    logic [30:0] r_reg, qp_reg, qv_reg;
    val_t p_reg [3];
    val_t v_reg [3];
    val_t a_reg [3];
    val_t b_reg [3];
    val_t c_reg [3];
    val_t z_reg [3];
    val_t t_reg, s_reg, k1_reg, k2_reg, y_reg;
    val_t p, v, a, b, c, z, dt, mul_a, mul_b, prod, divq;
    val_t s_sum;
    logic s_pos;
    logic div_busy;

    always_comb
    begin
        p = p_reg[cmd.axis];
        v = v_reg[cmd.axis];
        a = a_reg[cmd.axis];
        b = b_reg[cmd.axis];
        c = c_reg[cmd.axis];
        z = z_reg[cmd.axis];
        dt = val_t'({1'b0, dt_reg});
    end

    // Innovation variance of the current axis and whether it is positive.
    assign s_sum = cvkt_pkg::sat_add(a, val_t'({1'b0, r_reg}));
    assign s_pos = !s_sum[DW-1] && (s_sum != '0);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = dt;
        mul_b = v;
        unique case (cmd.op)
            cvkt_pkg::OP_T:  mul_b = c;
            cvkt_pkg::OP_A1: mul_b = b;
            cvkt_pkg::OP_A2: mul_b = t_reg;
            cvkt_pkg::OP_UP: begin mul_a = k1_reg; mul_b = y_reg; end
            cvkt_pkg::OP_UV: begin mul_a = k2_reg; mul_b = y_reg; end
            cvkt_pkg::OP_UA: begin mul_a = k1_reg; mul_b = a; end
            cvkt_pkg::OP_UB: begin mul_a = k1_reg; mul_b = b; end
            cvkt_pkg::OP_UC: begin mul_a = k2_reg; mul_b = b; end
            default: ;
        endcase
        prod = cvkt_pkg::fx_mul(mul_a, mul_b);
    end

    cvkt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   ((cmd.op == cvkt_pkg::OP_DIV2) ? b : a),
        .den   (s_reg),
        .busy  (div_busy),
        .quot  (divq)
    );
    assign sts = cvkt_pkg::sts_t'{div_busy: div_busy, s_pos: s_pos};

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg <= 16'd655;
            r_reg  <= 31'd3277;
            qp_reg <= 31'd66;
            qv_reg <= 31'd6554;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                cvkt_pkg::REG_TIME_STEP:  dt_reg <= cfg_data[15:0];
                cvkt_pkg::REG_MEAS_NOISE: r_reg  <= cfg_data;
                cvkt_pkg::REG_PROC_POS:   qp_reg <= cfg_data;
                cvkt_pkg::REG_PROC_VEL:   qv_reg <= cfg_data;
            endcase
        end
    end

    // Filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p_reg[i] <= '0;
                v_reg[i] <= '0;
                a_reg[i] <= cvkt_pkg::ONE;
                b_reg[i] <= '0;
                c_reg[i] <= cvkt_pkg::ONE;
            end
        end
        else
        begin
            unique case (cmd.op)
                cvkt_pkg::OP_LOAD:
                begin
                    p_reg[0] <= meas_x;
                    p_reg[1] <= meas_y;
                    p_reg[2] <= meas_z;
                end
                cvkt_pkg::OP_P:  p_reg[cmd.axis] <= cvkt_pkg::sat_add(p, prod);
                cvkt_pkg::OP_A1: a_reg[cmd.axis] <= cvkt_pkg::sat_add(a, prod);
                cvkt_pkg::OP_A2: a_reg[cmd.axis] <= cvkt_pkg::sat_add(a, prod);
                cvkt_pkg::OP_A3:
                begin
                    a_reg[cmd.axis] <= cvkt_pkg::sat_add(a, val_t'({1'b0, qp_reg}));
                    b_reg[cmd.axis] <= t_reg;
                    c_reg[cmd.axis] <= cvkt_pkg::sat_add(c, val_t'({1'b0, qv_reg}));
                end
                cvkt_pkg::OP_UP: p_reg[cmd.axis] <= cvkt_pkg::sat_add(p, prod);
                cvkt_pkg::OP_UV: v_reg[cmd.axis] <= cvkt_pkg::sat_add(v, prod);
                cvkt_pkg::OP_UA: a_reg[cmd.axis] <= cvkt_pkg::sat_sub(a, prod);
                cvkt_pkg::OP_UB: b_reg[cmd.axis] <= cvkt_pkg::sat_sub(b, prod);
                cvkt_pkg::OP_UC: c_reg[cmd.axis] <= cvkt_pkg::sat_sub(c, prod);
                default: ;
            endcase
        end
    end

    // Scratch registers; UB runs after UC uses the old b, so UC is issued first.
    always_ff @(posedge clk)
    begin
        if (cmd.op == cvkt_pkg::OP_LOAD || cmd.op == cvkt_pkg::OP_MEAS)
        begin
            z_reg[0] <= meas_x;
            z_reg[1] <= meas_y;
            z_reg[2] <= meas_z;
        end
        if (cmd.op == cvkt_pkg::OP_T) t_reg <= cvkt_pkg::sat_add(b, prod);
        if (cmd.op == cvkt_pkg::OP_S)
        begin
            s_reg  <= s_sum;
            y_reg  <= cvkt_pkg::sat_sub(z, p);
            k1_reg <= '0;
            k2_reg <= '0;
        end
        if (cmd.op == cvkt_pkg::OP_DIV1 && !div_busy && !cmd.div_start) k1_reg <= divq;
        if (cmd.op == cvkt_pkg::OP_DIV2 && !div_busy && !cmd.div_start) k2_reg <= divq;
    end

    assign pos_x = p_reg[0];
    assign pos_y = p_reg[1];
    assign pos_z = p_reg[2];
    assign vel_x = v_reg[0];
    assign vel_y = v_reg[1];
    assign vel_z = v_reg[2];
endmodule

FILE: rtl/cvkt_ctrl.sv
`timescale 1ns / 1ps

// Sequencer: walks three axes through predict, divide (if s > 0) and update.
module cvkt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    output cvkt_pkg::cmd_t cmd,
    input  cvkt_pkg::sts_t sts
);
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DIV1,
        ST_DIV2,
        ST_OUT
    } state_t;

    state_t     state_reg;
    logic       started_reg;
    logic       wait_reg;
    logic [1:0] axis_reg;
    cvkt_pkg::op_t op_reg;
    logic       accept;

    assign in_stall = (state_reg != ST_IDLE) && !(state_reg == ST_OUT && !out_stall);
    assign out_valid = (state_reg == ST_OUT);
    assign accept = in_valid && !in_stall;

    // The first measurement loads the position; later ones are only latched.
    always_comb
    begin
        cmd.axis = axis_reg;
        cmd.op = op_reg;
        cmd.div_start = 1'b0;
        if ((state_reg == ST_DIV1 || state_reg == ST_DIV2) && wait_reg) cmd.div_start = 1'b1;
        if (accept) cmd.op = started_reg ? cvkt_pkg::OP_MEAS : cvkt_pkg::OP_LOAD;
    end

    // State, axis and operation registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            wait_reg    <= 1'b0;
            axis_reg    <= '0;
            op_reg      <= cvkt_pkg::OP_NONE;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE, ST_OUT:
                begin
                    if (accept)
                    begin
                        started_reg <= 1'b1;
                        axis_reg <= '0;
                        if (started_reg)
                        begin
                            state_reg <= ST_RUN;
                            op_reg <= cvkt_pkg::OP_P;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                            op_reg <= cvkt_pkg::OP_NONE;
                        end
                    end
                    else
                    begin
                        op_reg <= cvkt_pkg::OP_NONE;
                        if (state_reg == ST_OUT && !out_stall) state_reg <= ST_IDLE;
                    end
                end
                ST_RUN:
                begin
                    unique case (op_reg)
                        cvkt_pkg::OP_P:  op_reg <= cvkt_pkg::OP_T;
                        cvkt_pkg::OP_T:  op_reg <= cvkt_pkg::OP_A1;
                        cvkt_pkg::OP_A1: op_reg <= cvkt_pkg::OP_A2;
                        cvkt_pkg::OP_A2: op_reg <= cvkt_pkg::OP_A3;
                        cvkt_pkg::OP_A3: op_reg <= cvkt_pkg::OP_S;
                        cvkt_pkg::OP_S:
                        begin
                            op_reg <= sts.s_pos ? cvkt_pkg::OP_DIV1 : cvkt_pkg::OP_UP;
                            if (sts.s_pos)
                            begin
                                state_reg <= ST_DIV1;
                                wait_reg <= 1'b1;
                            end
                        end
                        cvkt_pkg::OP_UP: op_reg <= cvkt_pkg::OP_UV;
                        cvkt_pkg::OP_UV: op_reg <= cvkt_pkg::OP_UA;
                        cvkt_pkg::OP_UA: op_reg <= cvkt_pkg::OP_UC;
                        cvkt_pkg::OP_UC: op_reg <= cvkt_pkg::OP_UB;
                        cvkt_pkg::OP_UB:
                        begin
                            if (axis_reg == 2'd2)
                            begin
                                state_reg <= ST_OUT;
                                op_reg <= cvkt_pkg::OP_NONE;
                            end
                            else
                            begin
                                axis_reg <= axis_reg + 2'd1;
                                op_reg <= cvkt_pkg::OP_P;
                            end
                        end
                        default: op_reg <= cvkt_pkg::OP_NONE;
                    endcase
                end
                ST_DIV1, ST_DIV2:
                begin
                    if (!wait_reg && !sts.div_busy)
                    begin
                        if (state_reg == ST_DIV1)
                        begin
                            state_reg <= ST_DIV2;
                            op_reg <= cvkt_pkg::OP_DIV2;
                            wait_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= ST_RUN;
                            op_reg <= cvkt_pkg::OP_UP;
                        end
                    end
                    else
                    begin
                        wait_reg <= 1'b0;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

FILE: tb/constant_velocity_kalman_tracker_core_test.sv
`timescale 1ns / 1ps

module constant_velocity_kalman_tracker_core_test;

    typedef logic signed [31:0] q16_t;
    typedef logic [5:0][31:0] track_t;   // pos x, y, z then vel x, y, z

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        bit          typed;
        track_t      want;
    } meas_row_t;

    localparam int SETTLE_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES = 1500;
    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = cvkt_pkg::REG_TIME_STEP;
    logic [30:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] meas_x = '0;
    logic signed [31:0] meas_y = '0;
    logic signed [31:0] meas_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z;

    // Tracker state mirrored by the predictor.
    q16_t trk_pos[3], trk_vel[3], trk_paa[3], trk_pab[3], trk_pbb[3];
    bit trk_loaded = 1'b0;
    logic [15:0] mir_dt = 16'd655;
    logic [30:0] mir_r = 31'd3277;
    logic [30:0] mir_qp = 31'd66;
    logic [30:0] mir_qv = 31'd6554;

    track_t filtered_q[$];
    int mismatches = 0;
    int meas_sent = 0;
    int tracks_seen = 0;
    int idle_cycles = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_left = 0;
    bit gaps_on = 1'b0;

    constant_velocity_kalman_tracker_core DUT (.*);

    // Clock, 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Saturating fixed-point helpers.
    function automatic q16_t clip(longint v);
        if (v > QMAX) return QMAX[31:0];
        if (v < QMIN) return QMIN[31:0];
        return v[31:0];
    endfunction

    function automatic q16_t fit_mag(longint m, bit neg);
        if (neg) return (m >= 64'sd2147483648) ? QMIN[31:0] : q16_t'(-m);
        return (m > QMAX) ? QMAX[31:0] : m[31:0];
    endfunction

    function automatic q16_t qmul(q16_t a, q16_t b);
        longint ma, mb;
        ma = (a < 0) ? -longint'(a) : longint'(a);
        mb = (b < 0) ? -longint'(b) : longint'(b);
        return fit_mag((ma * mb + 64'sd32768) >>> 16, (a < 0) != (b < 0));
    endfunction

    function automatic q16_t qdiv(q16_t n, q16_t d);
        longint m;
        m = (n < 0) ? -longint'(n) : longint'(n);
        return fit_mag(((m <<< 16) + (longint'(d) >>> 1)) / longint'(d), n < 0);
    endfunction

    // One axis of predict and update.
    task automatic track_axis(int ax, q16_t z);
        q16_t dt, p, v, a, b, c, t, s, k1, k2, y;
        dt = {16'd0, mir_dt};
        p = trk_pos[ax];
        v = trk_vel[ax];
        a = trk_paa[ax];
        b = trk_pab[ax];
        c = trk_pbb[ax];
        p = clip(longint'(p) + qmul(dt, v));
        t = clip(longint'(b) + qmul(dt, c));
        a = clip(longint'(a) + qmul(dt, b));
        a = clip(longint'(a) + qmul(dt, t));
        a = clip(longint'(a) + longint'(mir_qp));
        b = t;
        c = clip(longint'(c) + longint'(mir_qv));
        s = clip(longint'(a) + longint'(mir_r));
        k1 = '0;
        k2 = '0;
        if (s > 0)
        begin
            k1 = qdiv(a, s);
            k2 = qdiv(b, s);
        end
        y = clip(longint'(z) - longint'(p));
        trk_pos[ax] = clip(longint'(p) + qmul(k1, y));
        trk_vel[ax] = clip(longint'(v) + qmul(k2, y));
        trk_paa[ax] = clip(longint'(a) - qmul(k1, a));
        trk_pab[ax] = clip(longint'(b) - qmul(k1, b));
        trk_pbb[ax] = clip(longint'(c) - qmul(k2, b));
    endtask

    // Returns 1 and the filtered track when the measurement gives a result.
    task automatic track_measure(q16_t zx, q16_t zy, q16_t zz, output bit got,
                                 output track_t res);
        q16_t zv[3];
        zv = '{zx, zy, zz};
        got = trk_loaded;
        res = '0;
        if (!trk_loaded)
        begin
            for (int i = 0; i < 3; i++)
                trk_pos[i] = zv[i];
            trk_loaded = 1'b1;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
                track_axis(i, zv[i]);
            for (int i = 0; i < 3; i++)
            begin
                res[i] = trk_pos[i];
                res[3 + i] = trk_vel[i];
            end
        end
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!gaps_on || roll < 60) return 0;
        if (roll < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // Offer one measurement and hold it until the transaction completes.
    task automatic send_meas(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit typed,
                             track_t want);
        bit got;
        track_t res;
        int gap;
        in_valid <= 1'b1;
        meas_x <= x;
        meas_y <= y;
        meas_z <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_measure(x, y, z, got, res);
        if (got)
            filtered_q.push_back(typed ? want : res);
        meas_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_tracks();
        in_valid <= 1'b0;
        while (filtered_q.size() != 0)
            @(posedge clk);
    endtask

    // Write all four registers once the block is idle.
    task automatic load_tuning(logic [30:0] dt, logic [30:0] r, logic [30:0] qp,
                               logic [30:0] qv);
        drain_tracks();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= cvkt_pkg::REG_TIME_STEP;
        cfg_data <= dt;
        @(posedge clk);
        cfg_index <= cvkt_pkg::REG_MEAS_NOISE;
        cfg_data <= r;
        @(posedge clk);
        cfg_index <= cvkt_pkg::REG_PROC_POS;
        cfg_data <= qp;
        @(posedge clk);
        cfg_index <= cvkt_pkg::REG_PROC_VEL;
        cfg_data <= qv;
        @(posedge clk);
        cfg_we <= 1'b0;
        mir_dt = dt[15:0];
        mir_r = r;
        mir_qp = qp;
        mir_qv = qv;
    endtask

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'hffffffff;
            3: return 32'h00000001;
            default: return 32'h0;
        endcase
    endfunction

    // Mostly smooth trajectories with small noise, some wild and extreme points.
    task automatic run_tracks(int count);
        longint base[3], speed[3];
        logic [31:0] m[3];
        int roll;
        for (int i = 0; i < 3; i++)
        begin
            base[i] = $signed($urandom_range(0, 32'h00ffffff)) - 64'sd8388608;
            speed[i] = $signed($urandom_range(0, 4000)) - 64'sd2000;
        end
        for (int k = 0; k < count; k++)
        begin
            roll = $urandom_range(0, 99);
            for (int i = 0; i < 3; i++)
            begin
                if (roll < 80)
                    m[i] = clip(base[i] + speed[i] * k
                                + $signed($urandom_range(0, 2000)) - 1000);
                else if (roll < 92)
                    m[i] = $urandom;
                else
                    m[i] = pick_extreme();
            end
            send_meas(m[0], m[1], m[2], 1'b0, '0);
        end
    endtask

    // Receiver stalls: random runs, plus a requested long hold-off.
    always @(posedge clk)
    begin
        if (hold_seen != hold_seq)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (gaps_on && $urandom_range(0, 99) < 20)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                                         : $urandom_range(0, 3);
            out_stall <= 1'b0;
        end
    end

    // Compare each result transaction with the oldest prediction.
    always @(posedge clk)
    begin
        track_t got, want;
        string names[6];
        names = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z"};
        if (rst_n && out_valid && !out_stall)
        begin
            got = {vel_z, vel_y, vel_x, pos_z, pos_y, pos_x};
            tracks_seen++;
            if (filtered_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transaction at %0t", $realtime);
            end
            else
            begin
                want = filtered_q.pop_front();
                for (int i = 0; i < 6; i++)
                begin
                    if (got[i] !== want[i])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Result %0d %s: expected %h, got %h",
                                     tracks_seen, names[i], want[i], got[i]);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        meas_row_t rows[14];
        rows[0] = '{32'h0, 32'h0, 32'h0, 1'b0, '0};
        rows[1] = '{32'h0, 32'h0, 32'h0, 1'b1, '0};
        rows[2] = '{32'h7fffffff, 32'h80000000, 32'h0, 1'b0, '0};
        rows[3] = '{32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b0, '0};
        rows[4] = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, '0};
        rows[5] = '{32'h80000000, 32'h80000000, 32'h80000000, 1'b0, '0};
        rows[6] = '{32'h1, 32'hffffffff, 32'h00010000, 1'b0, '0};
        rows[7] = '{32'h0, 32'h0, 32'h0, 1'b0, '0};
        rows[8] = '{32'h00010000, 32'hfffe0000, 32'h00030000, 1'b0, '0};
        rows[9] = '{32'h00020000, 32'hfffc0000, 32'h00060000, 1'b0, '0};
        rows[10] = '{32'h00030000, 32'hfffa0000, 32'h00090000, 1'b0, '0};
        rows[11] = '{32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f, 1'b0, '0};
        rows[12] = '{32'haaaaaaaa, 32'h55555555, 32'hf0f0f0f0, 1'b0, '0};
        rows[13] = '{32'h00000100, 32'h00000200, 32'h00000300, 1'b0, '0};
        for (int i = 0; i < 3; i++)
        begin
            trk_pos[i] = '0;
            trk_vel[i] = '0;
            trk_paa[i] = 32'h00010000;
            trk_pab[i] = '0;
            trk_pbb[i] = 32'h00010000;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed measurements with reset tuning, back to back.
        foreach (rows[i])
            send_meas(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].want);

        // Default tuning with gaps, a long receiver hold-off and a full pause.
        gaps_on = 1'b1;
        run_tracks(100);
        hold_seq++;
        run_tracks(150);
        drain_tracks();
        run_tracks(50);

        // Largest tuning values.
        load_tuning(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
        run_tracks(250);

        // Smallest tuning: zero noise drives the innovation variance to zero.
        load_tuning(31'd1, 31'd0, 31'd0, 31'd0);
        run_tracks(250);

        // Random tuning, one stretch without idling.
        for (int ph = 0; ph < 4; ph++)
        begin
            load_tuning(31'($urandom), 31'($urandom_range(0, 200000)),
                        31'($urandom_range(0, 20000)),
                        ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                    : 31'($urandom_range(0, 90000)));
            gaps_on = (ph != 1);
            run_tracks(240);
        end
        gaps_on = 1'b1;

        drain_tracks();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d measurements, checked %0d filtered tracks over 7 tuning sets.",
                 meas_sent, tracks_seen);
        $display("Mismatches found: %0d", mismatches);
        if (mismatches == 0 && filtered_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
